FILE: rtl/core/rv_pkg.sv
// Shared types, widths and arithmetic helpers for the refraction pipeline.
// Used by rv_front, rv_sqrt, rv_back and refract_vector; depends on nothing.
`timescale 1ns / 1ps
package rv_pkg;

  localparam int FracBits = 14;
  localparam int CompW    = 16;
  localparam int EtaFrac  = 12;
  localparam int EtaW     = 16;

  // Widths of the intermediate terms at these fixed component formats.
  localparam int EiW      = 21;  // eta * component, rounded to Q.14
  localparam int EdW      = 21;  // eta * d, rounded to Q.14
  localparam int KW       = 16;  // k after clamping below 4.0
  localparam int SqInW    = KW + FracBits;
  localparam int SqSteps  = SqInW / 2;
  localparam int RootW    = 16;
  localparam int RemW     = 17;

  localparam logic signed [63:0] One     = 64'sd1 <<< FracBits;
  localparam logic signed [63:0] CompMax = (64'sd1 <<< (CompW - 1)) - 64'sd1;
  localparam logic signed [63:0] CompMin = -(64'sd1 <<< (CompW - 1));
  localparam logic signed [63:0] KMax    = (64'sd4 <<< FracBits) - 64'sd1;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [EiW-1:0]   ei_t;

  // Data that rides alongside the square root.
  typedef struct packed {
    comp_t [2:0] nv;
    ei_t   [2:0] ei;
    logic signed [EdW-1:0] ed;
    logic        tir;
  } side_t;

  // Divide by 2^s, rounding to nearest with ties away from zero.
  function automatic logic signed [63:0] rnd_shift(logic signed [63:0] x, int unsigned s);
    logic signed [63:0] h;
    logic signed [63:0] neg;
    h   = 64'sd1 <<< (s - 1);
    neg = $signed({63'd0, x[63]});
    return (x + h - neg) >>> s;
  endfunction

  // Saturate to the signed component range.
  function automatic comp_t sat_comp(logic signed [63:0] x);
    logic signed [63:0] y;
    y = (x > CompMax) ? CompMax : ((x < CompMin) ? CompMin : x);
    return y[CompW-1:0];
  endfunction

endpackage

FILE: rtl/core/rv_front.sv
// Front stages: dot product, eta-scaled terms and k = 1 - eta^2 (1 - d^2).
// Depends on rv_pkg.
`timescale 1ns / 1ps
module rv_front import rv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  comp_t [2:0]      iv_i,
  input  comp_t [2:0]      nv_i,
  input  logic [EtaW-1:0]  eta_i,
  output logic             valid_o,
  output logic [KW-1:0]    k_o,
  output side_t            side_o
);

  // Stage registers.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [17:0] dn1_q [3];
  ei_t   [2:0] ei1_q, ei2_q, ei3_q, ei4_q, ei5_q;
  comp_t [2:0] n1_q, n2_q, n3_q, n4_q, n5_q;
  logic [EtaW-1:0] eta1_q, eta2_q, eta3_q;
  comp_t d2_q;
  logic signed [17:0] dd3_q;
  logic signed [EdW-1:0] ed3_q, ed4_q, ed5_q;
  logic signed [20:0] eu4_q;
  logic [EtaW-1:0] eta4_q;
  logic [KW-1:0] k5_q;
  logic tir5_q;

  logic signed [17:0] dn1_d [3];
  ei_t [2:0] ei1_d;
  logic signed [63:0] dsum;
  logic signed [63:0] dd_w, ed_w, u_w, eu_w, k_w;
  logic signed [EtaW:0] eta_s2, eta_s3, eta_s4;

  // Per-component products, each rounded on its own.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dn1_d[j] = 18'(rnd_shift(64'($signed(iv_i[j]) * $signed(nv_i[j])), FracBits));
      ei1_d[j] = EiW'(rnd_shift(64'($signed({1'b0, eta_i}) * $signed(iv_i[j])), EtaFrac));
    end
  end

  // Dot product sum, d^2, eta*d, then the two eta scalings of u.
  always_comb begin
    dsum   = 64'(dn1_q[0]) + 64'(dn1_q[1]) + 64'(dn1_q[2]);
    eta_s2 = $signed({1'b0, eta2_q});
    dd_w   = rnd_shift(64'(d2_q * d2_q), FracBits);
    ed_w   = rnd_shift(64'(eta_s2 * d2_q), EtaFrac);
    eta_s3 = $signed({1'b0, eta3_q});
    u_w    = One - 64'(dd3_q);
    eu_w   = rnd_shift(64'(eta_s3 * $signed(u_w[17:0])), EtaFrac);
    eta_s4 = $signed({1'b0, eta4_q});
    k_w    = One - rnd_shift(64'(eu4_q * eta_s4), EtaFrac);
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dn1_q  <= dn1_d;
      ei1_q  <= ei1_d;
      n1_q   <= nv_i;
      eta1_q <= eta_i;

      d2_q   <= sat_comp(dsum);
      ei2_q  <= ei1_q;
      n2_q   <= n1_q;
      eta2_q <= eta1_q;

      dd3_q  <= dd_w[17:0];
      ed3_q  <= ed_w[EdW-1:0];
      ei3_q  <= ei2_q;
      n3_q   <= n2_q;
      eta3_q <= eta2_q;

      eu4_q  <= eu_w[20:0];
      eta4_q <= eta3_q;
      ed4_q  <= ed3_q;
      ei4_q  <= ei3_q;
      n4_q   <= n3_q;

      tir5_q <= k_w[63];
      k5_q   <= k_w[63] ? '0 : ((k_w > KMax) ? KMax[KW-1:0] : k_w[KW-1:0]);
      ed5_q  <= ed4_q;
      ei5_q  <= ei4_q;
      n5_q   <= n4_q;
    end
  end

  assign valid_o    = v5_q;
  assign k_o        = k5_q;
  assign side_o.nv  = n5_q;
  assign side_o.ei  = ei5_q;
  assign side_o.ed  = ed5_q;
  assign side_o.tir = tir5_q;

endmodule

FILE: rtl/core/rv_sqrt.sv
// Pipelined square root of k * 2^14, one result bit per stage.
// Depends on rv_pkg.
`timescale 1ns / 1ps
module rv_sqrt import rv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [KW-1:0]    k_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output logic [RemW-1:0]  rem_o,
  output side_t            side_o
);

  logic             vld_q  [SqSteps];
  logic [SqInW-1:0] val_q  [SqSteps];
  logic [RemW-1:0]  rem_q  [SqSteps];
  logic [RootW-1:0] root_q [SqSteps];
  side_t            side_q [SqSteps];

  for (genvar g = 0; g < SqSteps; g++) begin : g_step
    logic             vld_p;
    logic [SqInW-1:0] val_p;
    logic [RemW-1:0]  rem_p;
    logic [RootW-1:0] root_p;
    side_t            side_p;
    logic [RemW+1:0]  rem_sh;
    logic [RemW+1:0]  trial;
    logic             take;

    if (g == 0) begin : g_first
      assign vld_p  = valid_i;
      assign val_p  = {k_i, {FracBits{1'b0}}};
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign vld_p  = vld_q[g-1];
      assign val_p  = val_q[g-1];
      assign rem_p  = rem_q[g-1];
      assign root_p = root_q[g-1];
      assign side_p = side_q[g-1];
    end

    // Bring down the next two bits and try to subtract 4*root + 1.
    always_comb begin
      rem_sh = {rem_p, val_p[SqInW-1-2*g -: 2]};
      trial  = {1'b0, root_p, 2'b01};
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[g]  <= val_p;
        side_q[g] <= side_p;
        rem_q[g]  <= take ? RemW'(rem_sh - trial) : RemW'(rem_sh);
        root_q[g] <= {root_p[RootW-2:0], take};
      end
    end
  end

  assign valid_o = vld_q[SqSteps-1];
  assign root_o  = root_q[SqSteps-1];
  assign rem_o   = rem_q[SqSteps-1];
  assign side_o  = side_q[SqSteps-1];

endmodule

FILE: rtl/core/rv_back.sv
// Back stages: rounded sqrt, a = eta*d + sqrt(k), and t = eta*i - a*n.
// Depends on rv_pkg; holds the output register.
`timescale 1ns / 1ps
module rv_back import rv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [RootW-1:0] root_i,
  input  logic [RemW-1:0]  rem_i,
  input  side_t            side_i,
  output logic             valid_o,
  output comp_t [2:0]      t_o,
  output logic             tir_o
);

  logic va_q, vb_q, vc_q;
  logic signed [21:0] a_q;
  side_t sa_q, sb_q;
  logic signed [23:0] qn_q [3];
  logic signed [16:0] rn_q [3];
  comp_t [2:0] t_q;
  logic tir_q;

  logic [RootW-1:0] s_w;
  logic signed [21:0] a_d;
  logic signed [7:0] q_w;
  logic signed [FracBits:0] r_w;
  logic signed [23:0] qn_d [3];
  logic signed [16:0] rn_d [3];
  comp_t [2:0] t_d;
  logic signed [63:0] tw;

  // Round the root to nearest and add eta*d.
  always_comb begin
    s_w = root_i + RootW'(rem_i > RemW'(root_i));
    a_d = 22'(side_i.ed) + $signed({6'd0, s_w});
  end

  // Split a into whole and fraction parts for the scaling by n.
  always_comb begin
    q_w = a_q[21:FracBits];
    r_w = $signed({1'b0, a_q[FracBits-1:0]});
    for (int j = 0; j < 3; j++) begin
      qn_d[j] = 24'(q_w * sa_q.nv[j]);
      rn_d[j] = 17'(rnd_shift(64'(r_w * sa_q.nv[j]), FracBits));
    end
  end

  // Final difference, saturated; zero on total internal reflection.
  always_comb begin
    tw = '0;
    for (int j = 0; j < 3; j++) begin
      tw     = 64'(sb_q.ei[j]) - (64'(qn_q[j]) + 64'(rn_q[j]));
      t_d[j] = sb_q.tir ? '0 : sat_comp(tw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0; vb_q <= 1'b0; vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i; vb_q <= va_q; vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_d;
      sa_q  <= side_i;
      qn_q  <= qn_d;
      rn_q  <= rn_d;
      sb_q  <= sa_q;
      t_q   <= t_d;
      tir_q <= sb_q.tir;
    end
  end

  assign valid_o = vc_q;
  assign t_o     = t_q;
  assign tir_o   = tir_q;

endmodule

FILE: rtl/core/refract_vector.sv
// Top level of the fixed-point refraction pipeline.
// Depends on rv_pkg, rv_front, rv_sqrt and rv_back.
`timescale 1ns / 1ps
// A new word can be taken every cycle while the output is not stalled, and each
// result passes through five front stages, the fifteen-stage square root that
// resolves one root bit per stage, and three back stages. The pipeline
// advances as a whole: it moves whenever the output register is empty or being
// read, so a stalled output holds every stage in place.
module refract_vector import rv_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  comp_t           dir_x_i,
  input  comp_t           dir_y_i,
  input  comp_t           dir_z_i,
  input  comp_t           normal_x_i,
  input  comp_t           normal_y_i,
  input  comp_t           normal_z_i,
  input  logic [EtaW-1:0] eta_ratio_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output comp_t           out_x_o,
  output comp_t           out_y_o,
  output comp_t           out_z_o,
  output logic            total_internal_o
);

  logic en;
  logic f_valid, s_valid, b_valid;
  logic [KW-1:0] f_k;
  side_t f_side, s_side;
  logic [RootW-1:0] s_root;
  logic [RemW-1:0] s_rem;
  comp_t [2:0] b_t;
  comp_t [2:0] iv, nv;

  // Whole-pipeline advance.
  assign en         = out_ready_i | ~b_valid;
  assign in_ready_o = en;

  assign iv = {dir_z_i, dir_y_i, dir_x_i};
  assign nv = {normal_z_i, normal_y_i, normal_x_i};

  rv_front u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i & en),
    .iv_i(iv), .nv_i(nv), .eta_i(eta_ratio_i),
    .valid_o(f_valid), .k_o(f_k), .side_o(f_side)
  );

  rv_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(f_valid), .k_i(f_k), .side_i(f_side),
    .valid_o(s_valid), .root_o(s_root), .rem_o(s_rem), .side_o(s_side)
  );

  rv_back u_back (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s_valid), .root_i(s_root), .rem_i(s_rem), .side_i(s_side),
    .valid_o(b_valid), .t_o(b_t), .tir_o(total_internal_o)
  );

  assign out_valid_o = b_valid;
  assign out_x_o     = b_t[0];
  assign out_y_o     = b_t[1];
  assign out_z_o     = b_t[2];

endmodule
